>>> rtl/olsf_pkg.sv
// Package for the overload load-shedding controller.
// Holds payload structs, state and configuration types, and the fixed codes.
// Depends on nothing; every rtl file refers to it by scoped names.
package olsf_pkg;

  // Operation codes carried in an input request.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_FORCE  = 2'd2;

  // Phase codes of the controller.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_DETECT  = 2'd1;
  localparam logic [1:0] PH_SHED    = 2'd2;
  localparam logic [1:0] PH_RESTORE = 2'd3;

  // Event codes reported with each result.
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_DETECT    = 3'd1;
  localparam logic [2:0] EV_CLEARED   = 3'd2;
  localparam logic [2:0] EV_SHED      = 3'd3;
  localparam logic [2:0] EV_RESTORE   = 3'd4;
  localparam logic [2:0] EV_REDETECT  = 3'd5;
  localparam logic [2:0] EV_RESTORED  = 3'd6;
  localparam logic [2:0] EV_FORCED    = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_DETECT_THR = 3'd1;
  localparam logic [2:0] REG_RESTORE_DL = 3'd2;
  localparam logic [2:0] REG_MAX_SHED   = 3'd3;
  localparam logic [2:0] REG_FALLBACK   = 3'd4;

  // Configuration reset values.
  localparam logic [21:0] RST_DETECT_THR = 22'd10000;
  localparam logic [21:0] RST_RESTORE_DL = 22'd30000;
  localparam logic [21:0] RST_MAX_SHED   = 22'd300000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] current_amps;
    logic [7:0] subscribed_amps;
    logic       overload_seen;
  } olsf_in_t;

  typedef struct packed {
    logic [1:0]  fsm_state;
    logic [2:0]  event_code;
    logic        shed_all;
    logic        release_all;
    logic [2:0]  shed_mode;
    logic [15:0] event_total;
    logic [7:0]  peak_amps;
    logic [31:0] overload_ms_total;
  } olsf_out_t;

  typedef struct packed {
    logic        enable;
    logic [21:0] detect_threshold_ms;
    logic [21:0] restore_delay_ms;
    logic [21:0] max_shed_ms;
    logic [2:0]  fallback_mode;
  } olsf_cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  phase;
    logic [31:0] detect_begin;
    logic [31:0] shed_begin;
    logic [31:0] restore_begin;
    logic [7:0]  latched_current;
    logic [7:0]  latched_limit;
    logic        latched_overload;
    logic [15:0] shed_count;
    logic [7:0]  peak_current;
    logic [31:0] overload_total;
  } olsf_state_t;

endpackage

>>> rtl/olsf_step.sv
// Next-state and result logic for one request of the load-shedding controller.
// Purely combinational; depends on olsf_pkg for types and codes.
module olsf_step (
  input  olsf_pkg::olsf_state_t st,
  input  olsf_pkg::olsf_cfg_t   cfg,
  input  olsf_pkg::olsf_in_t    item,
  output olsf_pkg::olsf_state_t st_next,
  output olsf_pkg::olsf_out_t   result
);

  logic [31:0] now_inc;
  logic [31:0] detect_age;
  logic [31:0] shed_age;
  logic [31:0] restore_age;
  logic [2:0]  ev;
  logic        shed;
  logic        release_p;

  // Elapsed times are measured against the advanced clock, modulo 2^32.
  assign now_inc     = st.now_ms + 32'd1;
  assign detect_age  = now_inc - st.detect_begin;
  assign shed_age    = now_inc - st.shed_begin;
  assign restore_age = now_inc - st.restore_begin;

  // Phase machine and report handling.
  always_comb begin
    st_next   = st;
    ev        = olsf_pkg::EV_NONE;
    shed      = 1'b0;
    release_p = 1'b0;
    unique case (item.op)
      olsf_pkg::OP_TICK: begin
        st_next.now_ms = now_inc;
        if (cfg.enable) begin
          unique case (st.phase)
            olsf_pkg::PH_IDLE: begin
              if (st.latched_overload) begin
                st_next.phase        = olsf_pkg::PH_DETECT;
                st_next.detect_begin = now_inc;
                ev                   = olsf_pkg::EV_DETECT;
              end
            end
            olsf_pkg::PH_DETECT: begin
              if (!st.latched_overload) begin
                st_next.phase = olsf_pkg::PH_IDLE;
                ev            = olsf_pkg::EV_CLEARED;
              end else if (detect_age >= {10'd0, cfg.detect_threshold_ms}) begin
                st_next.phase      = olsf_pkg::PH_SHED;
                st_next.shed_begin = now_inc;
                st_next.shed_count = st.shed_count + 16'd1;
                shed               = 1'b1;
                ev                 = olsf_pkg::EV_SHED;
              end
            end
            olsf_pkg::PH_SHED: begin
              if ((shed_age >= {10'd0, cfg.max_shed_ms}) || !st.latched_overload) begin
                st_next.phase         = olsf_pkg::PH_RESTORE;
                st_next.restore_begin = now_inc;
                ev                    = olsf_pkg::EV_RESTORE;
              end
            end
            olsf_pkg::PH_RESTORE: begin
              if (st.latched_overload) begin
                st_next.phase        = olsf_pkg::PH_DETECT;
                st_next.detect_begin = now_inc;
                ev                   = olsf_pkg::EV_REDETECT;
              end else if (restore_age >= {10'd0, cfg.restore_delay_ms}) begin
                release_p              = 1'b1;
                st_next.overload_total = st.overload_total + shed_age;
                st_next.phase          = olsf_pkg::PH_IDLE;
                ev                     = olsf_pkg::EV_RESTORED;
              end
            end
          endcase
        end
      end
      olsf_pkg::OP_REPORT: begin
        st_next.latched_current  = item.current_amps;
        st_next.latched_limit    = item.subscribed_amps;
        st_next.latched_overload = item.overload_seen;
        if (item.current_amps > st.peak_current) begin
          st_next.peak_current = item.current_amps;
        end
      end
      olsf_pkg::OP_FORCE: begin
        if (st.phase != olsf_pkg::PH_IDLE) begin
          release_p     = 1'b1;
          st_next.phase = olsf_pkg::PH_IDLE;
          ev            = olsf_pkg::EV_FORCED;
        end
      end
      default: begin
        // The unused operation code leaves everything as it is.
      end
    endcase
  end

  // Result fields reflect the state after this request.
  always_comb begin
    result.fsm_state         = st_next.phase;
    result.event_code        = ev;
    result.shed_all          = shed;
    result.release_all       = release_p;
    result.shed_mode         = shed ? cfg.fallback_mode : 3'd0;
    result.event_total       = st_next.shed_count;
    result.peak_amps         = st_next.peak_current;
    result.overload_ms_total = st_next.overload_total;
  end

endmodule

>>> rtl/overload_load_shed_fsm_core.sv
// Top level of the overload load-shedding controller.
// Holds configuration, controller state and a two-entry result buffer;
// depends on olsf_pkg and olsf_step.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one request: a
//   millisecond tick, a current report or a force restore. A request is
//   taken at a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid, out_stall, out_data) returns exactly one
//   result per request, in order, taken when out_valid is high and
//   out_stall is low.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes one register per handshake; cfg_ready is always high and
//   indexes above the fallback mode register are ignored.
// Flow: each request is one compare-and-add pass in olsf_step, and its
//   result is registered into out_data, or into the skid entry while
//   out_data is held; one request per cycle is taken unless in_stall.
// Reset (rst, synchronous): clears the controller state to idle, loads the
//   register defaults and empties the result buffer.
// Stall: a result held by out_stall stays put; a second result goes to the
//   skid entry, and in_stall rises only while that entry is occupied.
module overload_load_shed_fsm_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  olsf_pkg::olsf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output olsf_pkg::olsf_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [21:0]         cfg_data
);

  olsf_pkg::olsf_cfg_t   cfg;
  olsf_pkg::olsf_state_t st;
  olsf_pkg::olsf_state_t st_next;
  olsf_pkg::olsf_out_t   result;
  olsf_pkg::olsf_out_t   skid_data;
  logic                  skid_valid;
  logic                  in_acc;
  logic                  out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable              <= 1'b1;
      cfg.detect_threshold_ms <= olsf_pkg::RST_DETECT_THR;
      cfg.restore_delay_ms    <= olsf_pkg::RST_RESTORE_DL;
      cfg.max_shed_ms         <= olsf_pkg::RST_MAX_SHED;
      cfg.fallback_mode       <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        olsf_pkg::REG_ENABLE:     cfg.enable              <= cfg_data[0];
        olsf_pkg::REG_DETECT_THR: cfg.detect_threshold_ms <= cfg_data;
        olsf_pkg::REG_RESTORE_DL: cfg.restore_delay_ms    <= cfg_data;
        olsf_pkg::REG_MAX_SHED:   cfg.max_shed_ms         <= cfg_data;
        olsf_pkg::REG_FALLBACK:   cfg.fallback_mode       <= cfg_data[2:0];
        default: begin
          // Writes past the last register are dropped.
        end
      endcase
    end
  end

  olsf_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (in_data),
    .st_next (st_next),
    .result  (result)
  );

  // Controller state advances on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  // Result register plus skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_acc) begin
        out_data <= result;
      end
    end else if (in_acc) begin
      skid_data <= result;
    end
  end

  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry occupied while output register is empty");

  // Every accepted tick advances the millisecond clock by exactly one.
  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.op == olsf_pkg::OP_TICK) |=> st.now_ms == $past(st.now_ms) + 32'd1)
    else $error("tick did not advance the clock by one");

  // A shed pulse bumps the event count and lands in the overloaded phase.
  a_shed_counts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && result.shed_all) |=>
      (st.shed_count == $past(st.shed_count) + 16'd1) && (st.phase == olsf_pkg::PH_SHED))
    else $error("shed pulse without count increment or phase change");

  // Reports never move the phase.
  a_report_holds_phase: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.op == olsf_pkg::OP_REPORT) |=> $stable(st.phase))
    else $error("current report changed the phase");

  // A release pulse always leaves the controller idle.
  a_release_to_idle: assert property (@(posedge clk) disable iff (rst)
    (in_acc && result.release_all) |=> st.phase == olsf_pkg::PH_IDLE)
    else $error("release pulse did not return to idle");

endmodule
